@@ hdl/stfd_pkg.sv @@
// Shared types, codes and constants for the service table filter with deduplication.
`default_nettype none

package stfd_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 256;
    localparam int unsigned DEF_COUNT_WIDTH = 8;

    localparam int unsigned REF_W  = 16;
    localparam int unsigned CTRY_W = 4;
    localparam int unsigned SUB_W  = 6;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned ATYP_W = 6;

    localparam int unsigned IDX_OUT_W = 8;
    localparam int unsigned CNT_OUT_W = 8;
    localparam int unsigned NUM_OUT_W = 9;

    localparam logic [MODE_W-1:0] MODE_AUDIO_STREAM = 2'd0;
    localparam logic [ATYP_W-1:0] ATYPE_DABPLUS     = 6'd63;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_COUNTED     = 3'd1,
        ST_NOT_PRIMARY = 3'd2,
        ST_NOT_AUDIO   = 3'd3,
        ST_NOT_DABPLUS = 3'd4,
        ST_ACCESS_CTRL = 3'd5,
        ST_FULL        = 3'd6,
        ST_CLEARED     = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        KIND_SEARCH = 2'd0,
        KIND_DROP   = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        t_kind              kind;
        t_status            drop_status;
        logic [REF_W-1:0]   service_ref;
        logic [CTRY_W-1:0]  country;
        logic [SUB_W-1:0]   subchannel;
        logic               last;
    } t_req;

    typedef struct packed {
        t_status                status;
        logic [IDX_OUT_W-1:0]   entry_index;
        logic [CNT_OUT_W-1:0]   receive_count;
        logic [NUM_OUT_W-1:0]   entry_count;
        logic [NUM_OUT_W-1:0]   twice_count;
        logic                   group_end;
    } t_rsp;

endpackage

`default_nettype wire

@@ hdl/stfd_table.sv @@
// Service table memory: one write port, one read port with registered read data.
`default_nettype none

module stfd_table #(
    parameter int unsigned DEPTH = stfd_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned WIDTH = 26 + stfd_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hdl/stfd_seq.sv @@
// Search sequencer: walks the table with one shared key compare, updates counts and counters.
`default_nettype none

module stfd_seq #(
    parameter int unsigned TABLE_DEPTH = stfd_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned COUNT_WIDTH = stfd_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire stfd_pkg::t_req                 i_req,
    output logic                                o_idle,
    output logic                                o_rsp_valid,
    input  wire logic                           i_rsp_ready,
    output stfd_pkg::t_rsp                      o_rsp,
    output logic                                o_mem_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_mem_wr_addr,
    output logic [26+COUNT_WIDTH-1:0]           o_mem_wr_data,
    output logic                                o_mem_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_mem_rd_addr,
    input  wire logic [26+COUNT_WIDTH-1:0]      i_mem_rd_data
);

    localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
    localparam int unsigned NUM_W   = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned REF_LO  = 0;
    localparam int unsigned CTRY_LO = REF_LO + stfd_pkg::REF_W;
    localparam int unsigned SUB_LO  = CTRY_LO + stfd_pkg::CTRY_W;
    localparam int unsigned CNT_LO  = SUB_LO + stfd_pkg::SUB_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    stfd_pkg::t_state r_state, n_state;
    stfd_pkg::t_req   r_req, n_req;
    stfd_pkg::t_rsp   r_rsp, n_rsp;
    logic [NUM_W-1:0] r_used, n_used;
    logic [NUM_W-1:0] r_twice, n_twice;
    logic [NUM_W-1:0] r_ptr, n_ptr;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;

    logic hit;
    logic scan_end;
    logic more;

    assign hit = r_rd_vld
              && (i_mem_rd_data[REF_LO +: stfd_pkg::REF_W] == r_req.service_ref)
              && (i_mem_rd_data[CTRY_LO +: stfd_pkg::CTRY_W] == r_req.country);
    assign more     = (r_ptr < r_used);
    assign scan_end = !r_rd_vld && !more;

    always_comb begin
        n_state = r_state;
        case (r_state)
            stfd_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_req.kind == stfd_pkg::KIND_SEARCH) ? stfd_pkg::S_SCAN
                                                                   : stfd_pkg::S_DONE;
                end
            end
            stfd_pkg::S_SCAN: begin
                if (hit || scan_end) begin
                    n_state = stfd_pkg::S_DONE;
                end
            end
            stfd_pkg::S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = stfd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stfd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        logic [COUNT_WIDTH-1:0] old_cnt;
        logic [COUNT_WIDTH-1:0] new_cnt;
        logic [NUM_W-1:0]       twice_nx;
        logic [NUM_W-1:0]       used_nx;

        old_cnt  = i_mem_rd_data[CNT_LO +: COUNT_WIDTH];
        new_cnt  = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_WIDTH'(1);
        twice_nx = r_twice;
        used_nx  = r_used + NUM_W'(1);

        n_req    = r_req;
        n_rsp    = r_rsp;
        n_used   = r_used;
        n_twice  = r_twice;
        n_ptr    = r_ptr;
        n_rd_vld = r_rd_vld;
        n_rd_idx = r_rd_idx;

        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_rd_idx;
        o_mem_wr_data = i_mem_rd_data;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_ptr[IDX_W-1:0];

        case (r_state)
            stfd_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req    = i_req;
                    n_ptr    = '0;
                    n_rd_vld = 1'b0;
                    n_rsp.entry_index   = '0;
                    n_rsp.receive_count = '0;
                    n_rsp.group_end     = i_req.last;
                    n_rsp.status        = i_req.drop_status;
                    n_rsp.entry_count   = stfd_pkg::NUM_OUT_W'(r_used);
                    n_rsp.twice_count   = stfd_pkg::NUM_OUT_W'(r_twice);
                    if (i_req.kind == stfd_pkg::KIND_CLEAR) begin
                        n_used = '0;
                        n_twice = '0;
                        n_rsp.status      = stfd_pkg::ST_CLEARED;
                        n_rsp.entry_count = '0;
                        n_rsp.twice_count = '0;
                    end
                end
            end
            stfd_pkg::S_SCAN: begin
                if (hit) begin
                    // bump the count of the first matching entry, saturating
                    if ((old_cnt != COUNT_MAX) && (new_cnt == COUNT_WIDTH'(2))) begin
                        twice_nx = r_twice + NUM_W'(1);
                    end
                    n_twice  = twice_nx;
                    n_rd_vld = 1'b0;
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_addr = r_rd_idx;
                    o_mem_wr_data = {new_cnt, i_mem_rd_data[CNT_LO-1:0]};
                    n_rsp.status        = stfd_pkg::ST_COUNTED;
                    n_rsp.entry_index   = stfd_pkg::IDX_OUT_W'(r_rd_idx);
                    n_rsp.receive_count = stfd_pkg::CNT_OUT_W'(new_cnt);
                    n_rsp.twice_count   = stfd_pkg::NUM_OUT_W'(twice_nx);
                end else if (scan_end) begin
                    if (r_used == NUM_W'(TABLE_DEPTH)) begin
                        n_rsp.status = stfd_pkg::ST_FULL;
                    end else begin
                        n_used        = used_nx;
                        o_mem_wr_en   = 1'b1;
                        o_mem_wr_addr = r_used[IDX_W-1:0];
                        o_mem_wr_data = {COUNT_WIDTH'(1), r_req.subchannel, r_req.country,
                                         r_req.service_ref};
                        n_rsp.status        = stfd_pkg::ST_INSERTED;
                        n_rsp.entry_index   = stfd_pkg::IDX_OUT_W'(r_used);
                        n_rsp.receive_count = stfd_pkg::CNT_OUT_W'(1);
                        n_rsp.entry_count   = stfd_pkg::NUM_OUT_W'(used_nx);
                    end
                end else begin
                    // issue the next read while the previous word is compared
                    o_mem_rd_en = more;
                    n_rd_vld    = more;
                    if (more) begin
                        n_ptr    = r_ptr + NUM_W'(1);
                        n_rd_idx = r_ptr[IDX_W-1:0];
                    end
                end
            end
            stfd_pkg::S_DONE: begin
                n_rd_vld = 1'b0;
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= stfd_pkg::S_IDLE;
            r_used   <= '0;
            r_twice  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_twice  <= n_twice;
            r_ptr    <= n_ptr;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_rsp    <= n_rsp;
        r_rd_idx <= n_rd_idx;
    end

    assign o_idle      = (r_state == stfd_pkg::S_IDLE);
    assign o_rsp_valid = (r_state == stfd_pkg::S_DONE);
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

@@ hdl/service_table_filter_dedup_top.sv @@
// Top level: stream ports, component filter, search sequencer, table and output register.
// Path: a dropped or clear item skips the table and goes straight to the done state, then
// into the output register once it is free; a searched item first walks the used entries,
// one read per cycle over the table port and the shared key compare (up to TABLE_DEPTH).
// Throughput: one item at a time; the next item is taken once the previous result has
// left the sequencer, so a waiting output item does not block acceptance.
// Reset: synchronous, active low; clears entry and twice counters, table contents are
// left undefined and are never read before being written.
`default_nettype none

module service_table_filter_dedup_top #(
    parameter int unsigned TABLE_DEPTH = stfd_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned COUNT_WIDTH = stfd_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [15:0] service_ref, [19:16] country, [20] is_primary, [22:21] transport_mode,
    // [28:23] audio_type, [29] access_control, [35:30] subchannel, [39:36] zero
    input  wire logic [39:0] i_s_tdata,
    // [0] command
    input  wire logic [0:0]  i_s_tuser,
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [7:0] entry_index, [15:8] receive_count, [24:16] entry_count,
    // [33:25] twice_count, [39:34] zero
    output logic [39:0]      o_m_tdata,
    // [2:0] status
    output logic [2:0]       o_m_tuser,
    output logic             o_m_tlast
);

    localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned WORD_W = 26 + COUNT_WIDTH;

    stfd_pkg::t_req req;
    stfd_pkg::t_rsp seq_rsp;
    stfd_pkg::t_rsp r_out;
    logic           r_out_vld;
    logic           seq_idle;
    logic           seq_rsp_valid;
    logic           rsp_ready;
    logic           accept;

    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [WORD_W-1:0]  mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [WORD_W-1:0]  mem_rd_data;

    logic       is_primary;
    logic [1:0] transport_mode;
    logic [5:0] audio_type;
    logic       access_control;

    assign is_primary     = i_s_tdata[20];
    assign transport_mode = i_s_tdata[22:21];
    assign audio_type     = i_s_tdata[28:23];
    assign access_control = i_s_tdata[29];

    // first failing check gives the drop reason
    always_comb begin
        req.service_ref = i_s_tdata[15:0];
        req.country     = i_s_tdata[19:16];
        req.subchannel  = i_s_tdata[35:30];
        req.last        = i_s_tlast;
        req.kind        = stfd_pkg::KIND_DROP;
        req.drop_status = stfd_pkg::ST_NOT_PRIMARY;
        if (i_s_tuser[0]) begin
            req.kind = stfd_pkg::KIND_CLEAR;
            req.drop_status = stfd_pkg::ST_CLEARED;
        end else if (!is_primary) begin
            req.drop_status = stfd_pkg::ST_NOT_PRIMARY;
        end else if (transport_mode != stfd_pkg::MODE_AUDIO_STREAM) begin
            req.drop_status = stfd_pkg::ST_NOT_AUDIO;
        end else if (audio_type != stfd_pkg::ATYPE_DABPLUS) begin
            req.drop_status = stfd_pkg::ST_NOT_DABPLUS;
        end else if (access_control) begin
            req.drop_status = stfd_pkg::ST_ACCESS_CTRL;
        end else begin
            req.kind = stfd_pkg::KIND_SEARCH;
            req.drop_status = stfd_pkg::ST_INSERTED;
        end
    end

    assign o_s_tready = seq_idle;
    assign accept     = i_s_tvalid && o_s_tready;
    assign rsp_ready  = !r_out_vld || i_m_tready;

    stfd_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_req         (req),
        .o_idle        (seq_idle),
        .o_rsp_valid   (seq_rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .o_rsp         (seq_rsp),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data)
    );

    stfd_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (seq_rsp_valid && rsp_ready) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_rsp_valid && rsp_ready) begin
            r_out <= seq_rsp;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, r_out.twice_count, r_out.entry_count,
                         r_out.receive_count, r_out.entry_index};
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.group_end;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("sequencer took a second item while still working");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == 3'(stfd_pkg::ST_CLEARED)))
        |-> (o_m_tdata[33:16] == 18'd0))
        else $error("clear result with non-zero counters");

    a_insert_count_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == 3'(stfd_pkg::ST_INSERTED)))
        |-> (o_m_tdata[15:8] == 8'd1))
        else $error("inserted entry without a receive count of one");

    a_drop_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && ((o_m_tuser == 3'(stfd_pkg::ST_NOT_PRIMARY))
                     || (o_m_tuser == 3'(stfd_pkg::ST_NOT_AUDIO))
                     || (o_m_tuser == 3'(stfd_pkg::ST_NOT_DABPLUS))
                     || (o_m_tuser == 3'(stfd_pkg::ST_ACCESS_CTRL))
                     || (o_m_tuser == 3'(stfd_pkg::ST_FULL))))
        |-> (o_m_tdata[15:0] == 16'd0))
        else $error("dropped or full result names a table entry");

endmodule

`default_nettype wire
